// ===== rtl/core/battery_gauge_filter_defines.svh =====
// ---------------------------------------------------------------------------
// battery_gauge_filter_defines.svh
// Assertion macros shared by the battery gauge checker.
// ---------------------------------------------------------------------------
`ifndef BATTERY_GAUGE_FILTER_DEFINES_SVH
`define BATTERY_GAUGE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BGF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BGF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bgf_pkg.sv =====
// ---------------------------------------------------------------------------
// bgf_pkg
// Shared widths, codes and handshake structs for the battery gauge filter.
// ---------------------------------------------------------------------------
package bgf_pkg;

  localparam int PinW     = 12;
  localparam int MvW      = 13;
  localparam int CntW     = 8;
  localparam int CapW     = 16;
  localparam int PctW     = 7;
  localparam int LvlW     = 2;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;

  localparam int AvgDepth = 8;
  localparam int IdxW     = (AvgDepth > 1) ? $clog2(AvgDepth) : 1;
  localparam int CntDepW  = $clog2(AvgDepth + 1);
  localparam int MaxMv    = 8190;
  localparam int SumW     = $clog2(AvgDepth * MaxMv + 1);

  // shared divider: widest dividend is capacity * 100
  localparam int NumW     = CapW + PctW;
  localparam int DenW     = MvW;
  localparam int StepW    = $clog2(NumW + 1);

  localparam logic [PctW-1:0] PctFull = PctW'(100);
  localparam logic [PctW-1:0] PctHi   = PctW'(40);
  localparam logic [PctW-1:0] PctLo   = PctW'(15);

  localparam logic [LvlW-1:0] LvlGood = LvlW'(0);
  localparam logic [LvlW-1:0] LvlMid  = LvlW'(1);
  localparam logic [LvlW-1:0] LvlLow  = LvlW'(2);

  // register indexes (byte address / 4)
  localparam logic [2:0] RegUsbThr  = 3'd0;
  localparam logic [2:0] RegConfirm = 3'd1;
  localparam logic [2:0] RegFull    = 3'd2;
  localparam logic [2:0] RegEmpty   = 3'd3;
  localparam logic [2:0] RegCap     = 3'd4;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] dividend;
    logic [DenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic           accept;
    logic           latch_en;
    logic [MvW-1:0] latch_mv;
  } trk_ctl_t;

  typedef struct packed {
    logic               usb_flag;
    logic               have_battery;
    logic [MvW-1:0]     last_mv;
    logic [SumW-1:0]    sum;
    logic [CntDepW-1:0] count;
  } trk_stat_t;

endpackage

// ===== rtl/core/bgf_div.sv =====
// ---------------------------------------------------------------------------
// bgf_div
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bgf_div
  import bgf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [NumW-1:0]   quo_q, quo_d;
  logic [DenW-1:0]   rem_q, rem_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [DenW:0]     trial;
  logic              ge;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = StepW'(NumW);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      quo_d  = {quo_q[NumW-2:0], ge};
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ===== rtl/core/bgf_track.sv =====
// ---------------------------------------------------------------------------
// bgf_track
// Power-presence debounce, sample ring with running sum, battery latch.
// ---------------------------------------------------------------------------
module bgf_track
  import bgf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  trk_ctl_t        ctl_i,
  input  logic [MvW-1:0]  mv_i,
  input  logic [MvW-1:0]  usb_thr_i,
  input  logic [CntW-1:0] confirm_i,
  output trk_stat_t       stat_o
);

  logic [MvW-1:0]     ring_q [AvgDepth];
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               full_q, full_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [CntDepW-1:0] count_q, count_d;
  logic [CntW-1:0]    high_q, high_d;
  logic [CntW-1:0]    low_q, low_d;
  logic               usb_q, usb_d;
  logic [MvW-1:0]     last_q, last_d;
  logic               have_q, have_d;
  logic [SumW-1:0]    drop;
  logic               wrap;

  assign drop = full_q ? SumW'(ring_q[idx_q]) : '0;
  assign wrap = (idx_q == IdxW'(AvgDepth - 1));

  always_comb begin
    idx_d   = idx_q;
    full_d  = full_q;
    sum_d   = sum_q;
    count_d = count_q;
    high_d  = high_q;
    low_d   = low_q;
    usb_d   = usb_q;
    last_d  = last_q;
    have_d  = have_q;
    if (ctl_i.accept) begin
      // saturating run counters on either side of the threshold
      if (mv_i >= usb_thr_i) begin
        low_d  = '0;
        high_d = (high_q < confirm_i) ? high_q + CntW'(1) : high_q;
        if (high_d >= confirm_i) usb_d = 1'b1;
      end else begin
        high_d = '0;
        low_d  = (low_q < confirm_i) ? low_q + CntW'(1) : low_q;
        if (low_d >= confirm_i) usb_d = 1'b0;
      end
      sum_d = sum_q - drop + SumW'(mv_i);
      if (wrap) begin
        idx_d  = '0;
        full_d = 1'b1;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
      count_d = (full_d || wrap) ? CntDepW'(AvgDepth) : CntDepW'(idx_d);
    end
    if (ctl_i.latch_en) begin
      last_d = ctl_i.latch_mv;
      have_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      full_q  <= 1'b0;
      sum_q   <= '0;
      count_q <= CntDepW'(1);
      high_q  <= '0;
      low_q   <= '0;
      usb_q   <= 1'b0;
      last_q  <= '0;
      have_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      full_q  <= full_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      high_q  <= high_d;
      low_q   <= low_d;
      usb_q   <= usb_d;
      last_q  <= last_d;
      have_q  <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) ring_q[idx_q] <= mv_i;
  end

  assign stat_o.usb_flag     = usb_q;
  assign stat_o.have_battery = have_q;
  assign stat_o.last_mv      = last_q;
  assign stat_o.sum          = sum_q;
  assign stat_o.count        = count_q;

endmodule

// ===== rtl/core/battery_gauge_filter.sv =====
// ---------------------------------------------------------------------------
// battery_gauge_filter
// Battery fuel gauge: moving average, debounced power detect, percent map.
// ---------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+----------------------------------
//  in      | in_valid_i / in_stall_o     | pin_mv_i
//  out     | out_valid_o / out_stall_i   | voltage_mv_o percent_o level_o
//          |                             | remaining_mah_o usb_present_o
//          |                             | held_value_o
//  cfg     | APB psel/penable/pwrite     | paddr, pwdata, prdata
//
// One sample runs from transfer to out_valid_o through three divisions on the
// shared 23-step divider (average, percent, remaining mAh); the percent one is
// skipped when the voltage clamps. Around them the FSM selects the voltage,
// clamps it, forms the mAh product and loads the output register.
// in_stall_o is high from the input transfer until the result is loaded into
// the output register, so the next sample is accepted only after that load;
// a stalled result holds there while the next sample is accepted.
// Reset restores register defaults and clears the tracking state.
// ---------------------------------------------------------------------------
module battery_gauge_filter
  import bgf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PinW-1:0]  pin_mv_i,

  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [MvW-1:0]   voltage_mv_o,
  output logic [PctW-1:0]  percent_o,
  output logic [LvlW-1:0]  level_o,
  output logic [CapW-1:0]  remaining_mah_o,
  output logic             usb_present_o,
  output logic             held_value_o,

  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  typedef enum logic [10:0] {
    StIdle = 11'b000_0000_0001,
    StAvg  = 11'b000_0000_0010,
    StAvgW = 11'b000_0000_0100,
    StVsel = 11'b000_0000_1000,
    StPct  = 11'b000_0001_0000,
    StPctS = 11'b000_0010_0000,
    StPctW = 11'b000_0100_0000,
    StRem  = 11'b000_1000_0000,
    StRemS = 11'b001_0000_0000,
    StRemW = 11'b010_0000_0000,
    StDone = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [MvW-1:0]  usb_thr_q;
  logic [CntW-1:0] confirm_q;
  logic [MvW-1:0]  full_q;
  logic [MvW-1:0]  empty_q;
  logic [CapW-1:0] cap_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usb_thr_q <= MvW'(4500);
      confirm_q <= CntW'(3);
      full_q    <= MvW'(4200);
      empty_q   <= MvW'(3300);
      cap_q     <= CapW'(1000);
    end else if (cfg_wr) begin
      unique case (paddr[AddrW-1:2])
        RegUsbThr:  usb_thr_q <= pwdata[MvW-1:0];
        RegConfirm: confirm_q <= pwdata[CntW-1:0];
        RegFull:    full_q    <= pwdata[MvW-1:0];
        RegEmpty:   empty_q   <= pwdata[MvW-1:0];
        RegCap:     cap_q     <= pwdata[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[AddrW-1:2])
      RegUsbThr:  prdata = DataW'(usb_thr_q);
      RegConfirm: prdata = DataW'(confirm_q);
      RegFull:    prdata = DataW'(full_q);
      RegEmpty:   prdata = DataW'(empty_q);
      RegCap:     prdata = DataW'(cap_q);
      default:    prdata = '0;
    endcase
  end

  // datapath
  trk_ctl_t        trk_ctl;
  trk_stat_t       trk_stat;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  logic            in_xfer;
  logic [MvW-1:0]  mv;
  logic [MvW-1:0]  avg_q, avg_d;
  logic [MvW-1:0]  volt_q, volt_d;
  logic            held_q, held_d;
  logic [NumW-1:0] num_q, num_d;
  logic [PctW-1:0] pct_q, pct_d;
  logic [CapW-1:0] rem_q, rem_d;
  logic [MvW-1:0]  diff;
  logic            load_out;

  logic             ov_q, ov_d;
  logic [MvW-1:0]   o_volt_q;
  logic [PctW-1:0]  o_pct_q;
  logic [LvlW-1:0]  o_lvl_q;
  logic [CapW-1:0]  o_rem_q;
  logic             o_usb_q;
  logic             o_held_q;
  logic [LvlW-1:0]  lvl;

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign mv         = {pin_mv_i, 1'b0};
  assign diff       = volt_q - empty_q;
  assign load_out   = (state_q == StDone) && (!ov_q || !out_stall_i);

  assign trk_ctl.accept   = in_xfer;
  assign trk_ctl.latch_en = (state_q == StVsel) && !trk_stat.usb_flag;
  assign trk_ctl.latch_mv = avg_q;

  bgf_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (trk_ctl),
    .mv_i      (mv),
    .usb_thr_i (usb_thr_q),
    .confirm_i (confirm_q),
    .stat_o    (trk_stat)
  );

  bgf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    avg_d   = avg_q;
    volt_d  = volt_q;
    held_d  = held_q;
    num_d   = num_q;
    pct_d   = pct_q;
    rem_d   = rem_q;
    div_req = '0;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) state_d = StAvg;
      end
      StAvg: begin
        div_req.start    = 1'b1;
        div_req.dividend = NumW'(trk_stat.sum);
        div_req.divisor  = DenW'(trk_stat.count);
        state_d          = StAvgW;
      end
      StAvgW: begin
        if (div_rsp.done) begin
          avg_d   = div_rsp.quot[MvW-1:0];
          state_d = StVsel;
        end
      end
      StVsel: begin
        held_d  = trk_stat.usb_flag && trk_stat.have_battery;
        volt_d  = held_d ? trk_stat.last_mv : avg_q;
        state_d = StPct;
      end
      StPct: begin
        if (volt_q >= full_q) begin
          pct_d   = PctFull;
          state_d = StRem;
        end else if (volt_q <= empty_q) begin
          pct_d   = '0;
          state_d = StRem;
        end else begin
          num_d   = NumW'(diff) * NumW'(PctFull);
          state_d = StPctS;
        end
      end
      StPctS: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_q;
        div_req.divisor  = full_q - empty_q;
        state_d          = StPctW;
      end
      StPctW: begin
        if (div_rsp.done) begin
          pct_d   = div_rsp.quot[PctW-1:0];
          state_d = StRem;
        end
      end
      StRem: begin
        num_d   = NumW'(cap_q) * NumW'(pct_q);
        state_d = StRemS;
      end
      StRemS: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_q;
        div_req.divisor  = DenW'(PctFull);
        state_d          = StRemW;
      end
      StRemW: begin
        if (div_rsp.done) begin
          rem_d   = div_rsp.quot[CapW-1:0];
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (pct_q > PctHi) begin
      lvl = LvlGood;
    end else if (pct_q > PctLo) begin
      lvl = LvlMid;
    end else begin
      lvl = LvlLow;
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (load_out) begin
      ov_d = 1'b1;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q   <= avg_d;
    volt_q  <= volt_d;
    held_q  <= held_d;
    num_q   <= num_d;
    pct_q   <= pct_d;
    rem_q   <= rem_d;
    if (load_out) begin
      o_volt_q <= volt_q;
      o_pct_q  <= pct_q;
      o_lvl_q  <= lvl;
      o_rem_q  <= rem_q;
      o_usb_q  <= trk_stat.usb_flag;
      o_held_q <= held_q;
    end
  end

  assign out_valid_o     = ov_q;
  assign voltage_mv_o    = o_volt_q;
  assign percent_o       = o_pct_q;
  assign level_o         = o_lvl_q;
  assign remaining_mah_o = o_rem_q;
  assign usb_present_o   = o_usb_q;
  assign held_value_o    = o_held_q;

endmodule

// ===== rtl/core/bgf_checker.sv =====
// ---------------------------------------------------------------------------
// bgf_checker
// Port-level checks on the battery gauge filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "battery_gauge_filter_defines.svh"

module bgf_checker
  import bgf_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [MvW-1:0]   voltage_mv_o,
  input logic [PctW-1:0]  percent_o,
  input logic [LvlW-1:0]  level_o,
  input logic [CapW-1:0]  remaining_mah_o,
  input logic             usb_present_o,
  input logic             held_value_o
);

  logic in_xfer;
  logic [LvlW-1:0] exp_lvl;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign exp_lvl = (percent_o > PctHi) ? LvlGood : ((percent_o > PctLo) ? LvlMid : LvlLow);

  `BGF_ASSERT_NXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, in_stall_o,
                  "input not stalled after a sample transfer")

  `BGF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(voltage_mv_o) && $stable(percent_o) &&
                  $stable(remaining_mah_o) && $stable(held_value_o),
                  "stalled result changed")

  `BGF_ASSERT_IMP(a_pct_range, clk_i, rst_ni, out_valid_o, percent_o <= PctFull,
                  "percent above full scale")

  `BGF_ASSERT_IMP(a_level_map, clk_i, rst_ni, out_valid_o, level_o == exp_lvl,
                  "level does not match percent")

  `BGF_ASSERT_IMP(a_held_usb, clk_i, rst_ni, out_valid_o && held_value_o, usb_present_o,
                  "held value reported without external power")

endmodule

bind battery_gauge_filter bgf_checker u_bgf_checker (.*);

// ===== tb/battery_gauge_filter_tb.sv =====
// ---------------------------------------------------------------------------
// battery_gauge_filter_tb
// Self-checking bench for the battery gauge filter. A short stimulus table
// covers the register extremes, power detection without a latched battery
// value, and full not above empty. Randomized phases follow, each with its
// own register setting, built from runs of samples on either side of the
// power threshold. Every result is checked field by field against an
// in-bench model of the averaging, debounce and percent logic, or against the result typed into its table row.
// ---------------------------------------------------------------------------
module battery_gauge_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bgf_pkg::*;

  localparam int CycleLimit   = 1_000_000;
  localparam int HoldCycles   = 600;
  localparam int RandomPhases = 10;
  localparam int PhaseItems   = 115;
  localparam int IdlePct      = 24;
  localparam int TailCycles   = 120;
  localparam int NumDir       = 33;

  // no register decodes here, writes must be dropped
  localparam logic [2:0] RegUnmapped = 3'd6;

  typedef struct packed {
    logic [MvW-1:0]  mv;
    logic [PctW-1:0] pct;
    logic [LvlW-1:0] lvl;
    logic [CapW-1:0] mah;
    logic            usb;
    logic            held;
  } reading_t;

  typedef struct packed {
    logic             is_cfg;
    logic [2:0]       reg_idx;
    logic [DataW-1:0] value;
    logic [PinW-1:0]  pin;
    logic             typed;
    reading_t         res;
  } dir_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [PinW-1:0]  pin_mv_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [MvW-1:0]   voltage_mv_o;
  logic [PctW-1:0]  percent_o;
  logic [LvlW-1:0]  level_o;
  logic [CapW-1:0]  remaining_mah_o;
  logic             usb_present_o;
  logic             held_value_o;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // gauge model: configuration
  logic [MvW-1:0]   cfg_thr     = 13'd4500;
  logic [CntW-1:0]  cfg_confirm = 8'd3;
  logic [MvW-1:0]   cfg_full    = 13'd4200;
  logic [MvW-1:0]   cfg_empty   = 13'd3300;
  logic [CapW-1:0]  cfg_cap     = 16'd1000;

  // gauge model: filter and debounce state
  logic [MvW-1:0]   ring_mv [AvgDepth];
  int unsigned      ring_pos     = 0;
  bit               ring_wrapped = 1'b0;
  int unsigned      ring_sum     = 0;
  int unsigned      hi_run       = 0;
  int unsigned      lo_run       = 0;
  bit               usb_seen     = 1'b0;
  int unsigned      batt_mv      = 0;
  bit               batt_valid   = 1'b0;

  reading_t         pending_readings [$];
  int unsigned      mismatch_cnt = 0;
  int unsigned      cycle_cnt    = 0;
  int               in_idle_pct  = IdlePct;
  int               out_idle_pct = IdlePct;
  int unsigned      hold_reqs    = 0;
  int unsigned      hold_done    = 0;
  int unsigned      hold_left    = 0;

  dir_row_t dir_rows [NumDir] = '{
    // threshold 0 flags power before any battery value is latched
    '{1'b1, RegUsbThr,   32'd0,    12'd0,    1'b0, '0},
    '{1'b1, RegConfirm,  32'd1,    12'd0,    1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd0,    1'b1, '{13'd0, 7'd0, LvlLow, 16'd0, 1'b1, 1'b0}},
    '{1'b0, RegUnmapped, 32'd0,    12'd4095, 1'b1,
      '{13'd4095, 7'd88, LvlGood, 16'd880, 1'b1, 1'b0}},
    // confirm 0: flag tracks every sample
    '{1'b1, RegUsbThr,   32'd8190, 12'd0,    1'b0, '0},
    '{1'b1, RegConfirm,  32'd0,    12'd0,    1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd4095, 1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd4094, 1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd4095, 1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'h555,  1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'hAAA,  1'b0, '0},
    '{1'b1, RegConfirm,  32'd255,  12'd0,    1'b0, '0},
    '{1'b1, RegUsbThr,   32'd4500, 12'd0,    1'b0, '0},
    '{1'b1, RegFull,     32'd8190, 12'd0,    1'b0, '0},
    '{1'b1, RegEmpty,    32'd0,    12'd0,    1'b0, '0},
    '{1'b1, RegCap,      32'd65535, 12'd0,   1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd4095, 1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd4095, 1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd4095, 1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd0,    1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd2000, 1'b0, '0},
    // full equal to empty, then full below empty
    '{1'b1, RegFull,     32'd3000, 12'd0,    1'b0, '0},
    '{1'b1, RegEmpty,    32'd3000, 12'd0,    1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd1500, 1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd1499, 1'b0, '0},
    '{1'b1, RegFull,     32'd0,    12'd0,    1'b0, '0},
    '{1'b1, RegEmpty,    32'd8190, 12'd0,    1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd4095, 1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd0,    1'b0, '0},
    '{1'b1, RegCap,      32'd0,    12'd0,    1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd1234, 1'b0, '0},
    '{1'b1, RegUnmapped, 32'hFFFF_FFFF, 12'd0, 1'b0, '0},
    '{1'b0, RegUnmapped, 32'd0,    12'd2100, 1'b0, '0}
  };

  battery_gauge_filter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pin_mv_i        (pin_mv_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .voltage_mv_o    (voltage_mv_o),
    .percent_o       (percent_o),
    .level_o         (level_o),
    .remaining_mah_o (remaining_mah_o),
    .usb_present_o   (usb_present_o),
    .held_value_o    (held_value_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("battery_gauge_filter_tb: done, errors");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) begin
      $display("cycle %0d: %0s mismatch, got %0d want %0d", cycle_cnt, what, got, want);
    end
  endtask

  function automatic reading_t predict_reading(input logic [PinW-1:0] pin);
    int unsigned mv, cnt, avg, shown, pct;
    reading_t r;
    mv = 2 * int'(pin);
    if (mv >= cfg_thr) begin
      lo_run = 0;
      if (hi_run < cfg_confirm) hi_run++;
      if (hi_run >= cfg_confirm) usb_seen = 1'b1;
    end else begin
      hi_run = 0;
      if (lo_run < cfg_confirm) lo_run++;
      if (lo_run >= cfg_confirm) usb_seen = 1'b0;
    end
    // oldest entry drops out only once the ring has wrapped
    if (ring_wrapped) ring_sum -= ring_mv[ring_pos];
    ring_mv[ring_pos] = MvW'(mv);
    ring_sum += mv;
    ring_pos++;
    if (ring_pos >= AvgDepth) begin
      ring_pos = 0;
      ring_wrapped = 1'b1;
    end
    cnt = ring_wrapped ? AvgDepth : ring_pos;
    if (cnt == 0) cnt = 1;
    avg = (ring_sum / cnt) & 32'h1FFF;
    if (!usb_seen) begin
      batt_mv = avg;
      batt_valid = 1'b1;
    end
    r.held = usb_seen && batt_valid;
    shown = r.held ? batt_mv : avg;
    if (shown >= cfg_full) pct = PctFull;
    else if (shown <= cfg_empty) pct = 0;
    else pct = (shown - cfg_empty) * 100 / (cfg_full - cfg_empty);
    r.mv  = MvW'(shown);
    r.pct = PctW'(pct);
    r.lvl = (pct > PctHi) ? LvlGood : ((pct > PctLo) ? LvlMid : LvlLow);
    r.mah = CapW'(cfg_cap * pct / 100);
    r.usb = usb_seen;
    return r;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] val);
    logic [DataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      RegUsbThr:  cfg_thr     = MvW'(val);
      RegConfirm: cfg_confirm = CntW'(val);
      RegFull:    cfg_full    = MvW'(val);
      RegEmpty:   cfg_empty   = MvW'(val);
      RegCap:     cfg_cap     = CapW'(val);
      default: ;
    endcase
    if (idx > RegCap) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end else begin
      // read back, psel stays up into the next setup cycle
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(negedge clk_i);
      rd = prdata;
      @(posedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd !== val) flag_mismatch("register readback", rd, val);
    end
    // the bus idles before the next access
    @(posedge clk_i);
  endtask

  task automatic push_sample(input logic [PinW-1:0] pin, input logic has_typed,
                             input reading_t typed_res);
    reading_t r;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pin_mv_i   <= pin;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_reading(pin);
    pending_readings.push_back(has_typed ? typed_res : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  // result side: check each transfer, then decide next cycle's stall
  initial begin
    reading_t got, want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.mv   = voltage_mv_o;
        got.pct  = percent_o;
        got.lvl  = level_o;
        got.mah  = remaining_mah_o;
        got.usb  = usb_present_o;
        got.held = held_value_o;
        if (pending_readings.size() == 0) begin
          flag_mismatch("unexpected result, voltage_mv", got.mv, 0);
        end else begin
          want = pending_readings.pop_front();
          if (got.mv !== want.mv)     flag_mismatch("voltage_mv", got.mv, want.mv);
          if (got.pct !== want.pct)   flag_mismatch("percent", got.pct, want.pct);
          if (got.lvl !== want.lvl)   flag_mismatch("level", got.lvl, want.lvl);
          if (got.mah !== want.mah)   flag_mismatch("remaining_mah", got.mah, want.mah);
          if (got.usb !== want.usb)   flag_mismatch("usb_present", got.usb, want.usb);
          if (got.held !== want.held) flag_mismatch("held_value", got.held, want.held);
        end
      end
      if (hold_reqs != hold_done) begin
        hold_left = HoldCycles;
        hold_done = hold_reqs;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  initial begin
    logic [DataW-1:0] new_thr, new_confirm, new_full, new_empty, new_cap;
    int unsigned      sel, run, sent, thr_half, low_max, b_lo, b_hi;
    bit               side;
    logic [PinW-1:0]  pin;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        apb_write(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        push_sample(dir_rows[i].pin, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int ph = 0; ph < RandomPhases; ph++) begin
      drain();
      case (ph)
        0: begin
          new_thr = 8190; new_confirm = 255; new_full = 8190; new_empty = 0; new_cap = 65535;
        end
        1: begin
          new_thr = 0; new_confirm = 1; new_full = 0; new_empty = 0; new_cap = 0;
        end
        default: begin
          new_thr   = $urandom_range(8190);
          new_empty = $urandom_range(6000);
          new_full  = ($urandom_range(5) == 0) ? $urandom_range(new_empty)
                                               : new_empty + $urandom_range(2190, 1);
          sel = $urandom_range(9);
          new_confirm = (sel == 9) ? 255 : sel;
          new_cap = $urandom_range(65535);
        end
      endcase
      apb_write(RegUsbThr, new_thr);
      apb_write(RegConfirm, new_confirm);
      apb_write(RegFull, new_full);
      apb_write(RegEmpty, new_empty);
      apb_write(RegCap, new_cap);
      in_idle_pct  = (ph == 4) ? 0 : IdlePct;
      out_idle_pct = (ph == 4) ? 0 : IdlePct;

      sent = 0;
      while (sent < PhaseItems) begin
        // runs on one side of the threshold, around the confirm length
        side = $urandom_range(1);
        run  = $urandom_range(cfg_confirm + 3, 1);
        for (int k = 0; k < run && sent < PhaseItems; k++) begin
          thr_half = (cfg_thr + 1) / 2;
          if ($urandom_range(99) < 15) begin
            pin = PinW'($urandom_range(4095));
          end else if (side || cfg_thr == 0) begin
            pin = ($urandom_range(3) == 0) ? PinW'(thr_half)
                                           : PinW'($urandom_range(4095, thr_half));
          end else begin
            low_max = (cfg_thr - 1) / 2;
            b_lo = (cfg_empty > 100) ? (cfg_empty - 100) / 2 : 0;
            b_hi = (cfg_full + 100) / 2;
            if (b_hi > low_max) b_hi = low_max;
            if (b_lo > b_hi) b_lo = b_hi;
            pin = $urandom_range(1) ? PinW'($urandom_range(b_hi, b_lo))
                                    : PinW'($urandom_range(low_max));
          end
          // long output hold while samples keep coming
          if (ph == 3 && sent == 10) hold_reqs++;
          push_sample(pin, 1'b0, '0);
          sent++;
        end
      end
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_readings.size() != 0) begin
      flag_mismatch("results never delivered", pending_readings.size(), 0);
    end
    if (mismatch_cnt == 0) begin
      $display("battery_gauge_filter_tb: done, clean");
    end else begin
      $display("battery_gauge_filter_tb: done, errors");
    end
    $finish;
  end

endmodule
